// ===== src/zpc_pkg.sv =====
`default_nettype none

package zpc_pkg;

  // window geometry: three kernel rows and columns, held by three column cells
  localparam int KERNEL_MAX = 3;

  localparam int PIX_W   = 8;
  localparam int PIX_MAX = 255;
  localparam int COEF_W  = 16;

  // signed product of an unsigned byte and a coefficient, and its sums
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int PSUM_W = PROD_W + 2;
  localparam int SUM_W  = PSUM_W + 2;

  // stages from acceptance to the result queue
  localparam int PIPE_N = 5;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef pix_t  [KERNEL_MAX-1:0]   pix_col_t;
  typedef coef_t [KERNEL_MAX-1:0]   coef_col_t;

  typedef struct packed {
    pix_t value;
    logic frame_last;
  } res_word_t;

  typedef enum logic [2:0] {
    REG_KERNEL_WIDTH  = 3'd0,
    REG_KERNEL_HEIGHT = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MID    = 3'd3,
    REG_KERNEL_BOT    = 3'd4,
    REG_ROW_BYTES     = 3'd5,
    REG_IMAGE_ROWS    = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_t;

endpackage

`default_nettype wire

// ===== src/zero_padded_2d_convolution.sv =====
`default_nettype none

// channel   direction  ports                                     word
// --------  ---------  ----------------------------------------  -----------------------------
// in        sink       in_valid/in_ready, in_action, in_pixel    one raster byte or flush tick
// out       source     out_valid/out_ready, out_value,           one convolved byte
//                      out_frame_last
// cfg       sink       cfg_valid/cfg_ready, cfg_index, cfg_data  one register write
//
// One word per clock while in_ready is high: every stage takes a new word each cycle, and
// each line buffer does one read and one write per cycle.
// Reset (rst_n low, synchronous) restores the register defaults and empties all counters
// and the result queue; line buffers keep stale data, which zero padding masks out.
// in_ready depends only on the queue fill and the words in flight, never on out_ready:
// an 8-word queue absorbs the pipeline while out_ready is low.
// cfg_ready is always high.

module zero_padded_2d_convolution
  import zpc_pkg::*;
#(
  parameter int MAX_ROW_BYTES  = 2048,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_pixel,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_value,
  output logic        out_frame_last,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  // column index, row-length value, and a compare width that holds both plus one
  localparam int CW   = $clog2(MAX_ROW_BYTES);
  localparam int WW   = $clog2(MAX_ROW_BYTES + 1);
  localparam int CMPW = (WW > 12) ? WW : 12;
  localparam int XW   = CMPW + 2;
  localparam int HW   = 12;
  localparam int VRW  = HW + 1;
  localparam int YW   = HW + 2;
  localparam int OCW  = 5;

  // ---------------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------------
  logic [1:0]  kw_cfg_r;
  logic [1:0]  kh_cfg_r;
  logic [47:0] krow_r [KERNEL_MAX];
  logic [11:0] row_bytes_r;
  logic [11:0] image_rows_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_cfg_r     <= 2'd3;
      kh_cfg_r     <= 2'd3;
      krow_r[0]    <= 48'd0;
      krow_r[1]    <= 48'h0000_0100_0000;
      krow_r[2]    <= 48'd0;
      row_bytes_r  <= 12'd640;
      image_rows_r <= 12'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KERNEL_WIDTH:  kw_cfg_r     <= cfg_data[1:0];
        REG_KERNEL_HEIGHT: kh_cfg_r     <= cfg_data[1:0];
        REG_KERNEL_TOP:    krow_r[0]    <= cfg_data;
        REG_KERNEL_MID:    krow_r[1]    <= cfg_data;
        REG_KERNEL_BOT:    krow_r[2]    <= cfg_data;
        REG_ROW_BYTES:     row_bytes_r  <= cfg_data[11:0];
        REG_IMAGE_ROWS:    image_rows_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, row length capped at the buffer depth
  logic [1:0]    kw, kh;
  logic [1:0]    dc, dr;        // columns / rows of look-ahead past the center
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    kw = (kw_cfg_r == 2'd0) ? 2'd1 : kw_cfg_r;
    kh = (kh_cfg_r == 2'd0) ? 2'd1 : kh_cfg_r;
    dc = kw - 2'd1 - (kw >> 1);
    dr = kh - 2'd1 - (kh >> 1);
    if (row_bytes_r == 12'd0) begin
      w_eff = WW'(1);
    end else if (CMPW'(row_bytes_r) > CMPW'(MAX_ROW_BYTES)) begin
      w_eff = WW'(MAX_ROW_BYTES);
    end else begin
      w_eff = WW'(row_bytes_r);
    end
    h_eff = (image_rows_r == 12'd0) ? HW'(1) : image_rows_r;
  end

  // coefficient grid and its mapping onto cell (age) and slot (row age)
  coef_t kcoef [KERNEL_MAX][KERNEL_MAX];
  coef_t csel  [KERNEL_MAX][KERNEL_MAX];

  always_comb begin
    for (int r = 0; r < KERNEL_MAX; r++) begin
      for (int c = 0; c < KERNEL_MAX; c++) begin
        kcoef[r][c] = coef_t'(krow_r[r][c*COEF_W +: COEF_W]);
      end
    end
  end

  // cell a holds the column a words old -> kernel column kw-1-a;
  // slot s holds row r-(K-1-s) -> kernel row s+kh-K
  always_comb begin
    int ki, kj;
    for (int a = 0; a < KERNEL_MAX; a++) begin
      for (int s = 0; s < KERNEL_MAX; s++) begin
        ki = s + int'(kh) - KERNEL_MAX;
        kj = int'(kw) - 1 - a;
        if (ki >= 0 && kj >= 0) begin
          csel[a][s] = kcoef[2'(ki)][2'(kj)];
        end else begin
          csel[a][s] = '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // position counters
  //   vcol/vrow: position of the next word; keeps running past the frame on flushes
  //   ox/oy:     position of the next result
  // ---------------------------------------------------------------------------------
  logic [CW-1:0]  vcol_r, vcol_nxt;
  logic [VRW-1:0] vrow_r, vrow_nxt;
  logic [CW-1:0]  ox_r, ox_nxt;
  logic [HW-1:0]  oy_r, oy_nxt;

  logic acc, is_pix, all_in, go, emit_pos, emit, last;
  logic vcol_wrap, ox_wrap, oy_wrap;
  pix_t wr_pix;

  assign acc       = in_valid && in_ready;
  assign is_pix    = (action_t'(in_action) == ACT_PIXEL);
  assign all_in    = vrow_r >= {1'b0, h_eff};
  assign go        = acc && (all_in || is_pix);
  assign emit_pos  = (vrow_r > VRW'(dr)) || ((vrow_r == VRW'(dr)) && (vcol_r >= CW'(dc)));
  assign emit      = go && (all_in || emit_pos);
  assign vcol_wrap = (CMPW'(vcol_r) + CMPW'(1)) >= CMPW'(w_eff);
  assign ox_wrap   = (CMPW'(ox_r) + CMPW'(1)) >= CMPW'(w_eff);
  assign oy_wrap   = (VRW'(oy_r) + VRW'(1)) >= VRW'(h_eff);
  assign last      = emit && ox_wrap && oy_wrap;
  // past the frame the stream carries zeros (masked anyway)
  assign wr_pix    = (is_pix && !all_in) ? in_pixel : '0;

  always_comb begin
    vcol_nxt = vcol_r;
    vrow_nxt = vrow_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    if (go) begin
      if (vcol_wrap) begin
        vcol_nxt = '0;
        vrow_nxt = vrow_r + 1'b1;
      end else begin
        vcol_nxt = vcol_r + 1'b1;
      end
    end
    if (emit) begin
      if (ox_wrap) begin
        ox_nxt = '0;
        oy_nxt = oy_r + 1'b1;
      end else begin
        ox_nxt = ox_r + 1'b1;
      end
      if (last) begin
        vcol_nxt = '0;
        vrow_nxt = '0;
        ox_nxt   = '0;
        oy_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcol_r <= '0;
      vrow_r <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
    end else begin
      vcol_r <= vcol_nxt;
      vrow_r <= vrow_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
    end
  end

  // zero-padding masks for the result being produced: slot s is row oy+dr-(K-1-s),
  // cell a is column ox+dc-a
  logic [KERNEL_MAX-1:0] smask, amask;

  always_comb begin
    logic signed [YW-1:0] yy;
    logic signed [XW-1:0] xx;
    for (int s = 0; s < KERNEL_MAX; s++) begin
      yy = $signed({2'b00, oy_r}) + $signed(YW'(dr)) - $signed(YW'(KERNEL_MAX - 1 - s));
      smask[s] = (s + int'(kh) >= KERNEL_MAX) && (yy >= 0) &&
                 (yy < $signed({2'b00, h_eff}));
    end
    for (int a = 0; a < KERNEL_MAX; a++) begin
      xx = $signed(XW'(ox_r)) + $signed(XW'(dc)) - $signed(XW'(a));
      amask[a] = (a < int'(kw)) && (xx >= 0) && (xx < $signed(XW'(w_eff)));
    end
  end

  // ---------------------------------------------------------------------------------
  // line buffers: lb1 holds the previous row, lb2 the one before
  // ---------------------------------------------------------------------------------
  logic                  v1_r;
  pix_t                  pix1_r;
  logic [CW-1:0]         col1_r;
  logic [KERNEL_MAX-1:0] smask1_r, amask1_r;
  pix_t                  byp_r;
  logic                  byp_sel_r;
  logic                  byp_hit;
  pix_t                  lb1_rd, lb2_rd, lb2_val;

  zpc_line_buf #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (CW)
  ) u_lb1 (
    .clk     (clk),
    .wr_en   (go),
    .wr_addr (vcol_r),
    .wr_data (wr_pix),
    .rd_en   (go),
    .rd_addr (vcol_r),
    .rd_data (lb1_rd)
  );

  // lb2 takes what lb1 held at the same column, in the cycle after the lb1 read
  zpc_line_buf #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (CW)
  ) u_lb2 (
    .clk     (clk),
    .wr_en   (v1_r),
    .wr_addr (col1_r),
    .wr_data (lb1_rd),
    .rd_en   (go),
    .rd_addr (vcol_r),
    .rd_data (lb2_rd)
  );

  // one-byte rows: the lb2 write lands on the column being read
  assign byp_hit = v1_r && (col1_r == vcol_r);
  assign lb2_val = byp_sel_r ? byp_r : lb2_rd;

  // ---------------------------------------------------------------------------------
  // pipeline control: stage 1 has the new column, then cell bytes, products, cell sums, total
  // ---------------------------------------------------------------------------------
  logic [PIPE_N-1:0] emit_pipe_r, last_pipe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      emit_pipe_r <= '0;
      last_pipe_r <= '0;
    end else begin
      v1_r        <= go;
      emit_pipe_r <= {emit_pipe_r[PIPE_N-2:0], emit};
      last_pipe_r <= {last_pipe_r[PIPE_N-2:0], last};
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      pix1_r    <= wr_pix;
      col1_r    <= vcol_r;
      smask1_r  <= smask;
      amask1_r  <= amask;
      byp_r     <= lb1_rd;
      byp_sel_r <= byp_hit;
    end
  end

  // ---------------------------------------------------------------------------------
  // chain of column cells
  // ---------------------------------------------------------------------------------
  pix_col_t                 col_in;
  pix_col_t                 chain_in  [KERNEL_MAX];
  pix_col_t                 cell_pix  [KERNEL_MAX];
  coef_col_t                cell_coef [KERNEL_MAX];
  logic signed [PSUM_W-1:0] cell_psum [KERNEL_MAX];

  always_comb begin
    col_in[0] = lb2_val;
    col_in[1] = lb1_rd;
    col_in[2] = pix1_r;
  end

  // padded positions get a zero coefficient
  always_comb begin
    for (int a = 0; a < KERNEL_MAX; a++) begin
      for (int s = 0; s < KERNEL_MAX; s++) begin
        cell_coef[a][s] = (smask1_r[s] && amask1_r[a]) ? csel[a][s] : '0;
      end
    end
  end

  for (genvar a = 0; a < KERNEL_MAX; a++) begin : g_cell
    if (a == 0) begin : g_head
      assign chain_in[a] = col_in;
    end else begin : g_link
      assign chain_in[a] = cell_pix[a-1];
    end

    zpc_cell u_cell (
      .clk      (clk),
      .shift_en (v1_r),
      .pix_in   (chain_in[a]),
      .coef_in  (cell_coef[a]),
      .pix_out  (cell_pix[a]),
      .psum     (cell_psum[a])
    );
  end

  // ---------------------------------------------------------------------------------
  // total, fraction drop and clamp
  // ---------------------------------------------------------------------------------
  logic signed [SUM_W-1:0] total_r, total_nxt;
  logic signed [SUM_W-1:0] shifted;
  pix_t                    res_value;

  always_comb begin
    total_nxt = '0;
    for (int a = 0; a < KERNEL_MAX; a++) begin
      total_nxt = total_nxt +
                  $signed({{(SUM_W-PSUM_W){cell_psum[a][PSUM_W-1]}}, cell_psum[a]});
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
  end

  always_comb begin
    shifted = total_r >>> COEF_FRAC_BITS;
    if (total_r <= 0) begin
      res_value = '0;
    end else if (shifted > SUM_W'(PIX_MAX)) begin
      res_value = pix_t'(PIX_MAX);
    end else begin
      res_value = shifted[PIX_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------------
  // result queue and input credit
  // ---------------------------------------------------------------------------------
  res_word_t          push_word, head_word;
  logic               pop;
  logic [FIFO_CW-1:0] fifo_count;
  logic [OCW-1:0]     occupancy;

  assign push_word.value      = res_value;
  assign push_word.frame_last = last_pipe_r[PIPE_N-1];

  zpc_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (emit_pipe_r[PIPE_N-1]),
    .push_word (push_word),
    .pop_en    (pop),
    .head_word (head_word),
    .count     (fifo_count)
  );

  assign out_valid      = (fifo_count != '0);
  assign pop            = out_valid && out_ready;
  assign out_value      = head_word.value;
  assign out_frame_last = head_word.frame_last;

  // a new word is taken only if every result already in flight still has a queue slot
  assign occupancy = OCW'(fifo_count) + OCW'($countones(emit_pipe_r));
  assign in_ready  = occupancy < OCW'(FIFO_DEPTH);

endmodule

`default_nettype wire

// ===== src/zpc_line_buf.sv =====
`default_nettype none

// one row of history, read-first when the read and write addresses match
module zpc_line_buf
  import zpc_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pix_t          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output pix_t          rd_data
);

  pix_t mem_r [DEPTH];
  pix_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== src/zpc_cell.sv =====
`default_nettype none

// one window column: holds its bytes and coefficients, passes bytes on
module zpc_cell
  import zpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     shift_en,
  input  pix_col_t                 pix_in,
  input  coef_col_t                coef_in,
  output pix_col_t                 pix_out,
  output logic signed [PSUM_W-1:0] psum
);

  pix_col_t                 pix_r;
  coef_col_t                coef_r;
  logic signed [PROD_W-1:0] prod_r   [KERNEL_MAX];
  logic signed [PROD_W-1:0] prod_nxt [KERNEL_MAX];
  logic signed [PSUM_W-1:0] psum_r, psum_nxt;

  // a zero coefficient marks a padded slot, whose byte may never have been written
  always_comb begin
    for (int s = 0; s < KERNEL_MAX; s++) begin
      if (coef_r[s] == '0) begin
        prod_nxt[s] = '0;
      end else begin
        prod_nxt[s] = $signed({{(PROD_W-PIX_W){1'b0}}, pix_r[s]}) *
                      $signed({{(PROD_W-COEF_W){coef_r[s][COEF_W-1]}}, coef_r[s]});
      end
    end
  end

  always_comb begin
    psum_nxt = '0;
    for (int s = 0; s < KERNEL_MAX; s++) begin
      psum_nxt = psum_nxt + $signed({{(PSUM_W-PROD_W){prod_r[s][PROD_W-1]}}, prod_r[s]});
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix_r  <= pix_in;
      coef_r <= coef_in;
    end
    for (int s = 0; s < KERNEL_MAX; s++) begin
      prod_r[s] <= prod_nxt[s];
    end
    psum_r <= psum_nxt;
  end

  assign pix_out = pix_r;
  assign psum    = psum_r;

endmodule

`default_nettype wire

// ===== src/zpc_out_fifo.sv =====
`default_nettype none

// result queue behind the arithmetic pipeline
module zpc_out_fifo
  import zpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_en,
  input  res_word_t          push_word,
  input  logic               pop_en,
  output res_word_t          head_word,
  output logic [FIFO_CW-1:0] count
);

  res_word_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push_en, pop_en})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head_word = mem_r[rd_ptr_r];
  assign count     = count_r;

endmodule

`default_nettype wire

// ===== test/conv_checker.sv =====
`default_nettype none

// Watches the three channels, keeps its own copy of the registers, the raster
// history and the frame counters, and compares every result word with the
// oldest predicted one.
module conv_checker
  import zpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_pixel,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_value,
  input  logic        out_frame_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_MAX    = 2048;
  localparam int unsigned ROWS_MAX   = 4095;
  localparam int unsigned HIST_DEPTH = KERNEL_MAX * ROW_MAX;
  localparam int unsigned FRAC       = 8;
  localparam int          REPORT_MAX = 100;

  logic [1:0]  k_cols;
  logic [1:0]  k_rows;
  logic [47:0] coef_rows [KERNEL_MAX];
  logic [11:0] row_len;
  logic [11:0] frame_rows;

  logic [7:0]  hist [HIST_DEPTH];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned out_pos;
  res_word_t   expected_q [$];

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // zero-padded window sum at linear output position p
  function automatic logic [7:0] conv_at(int p, int w, int h, int kw, int kh);
    longint acc;
    longint t;
    int y, x, yy, xx, i, j;
    logic signed [15:0] c;
    acc = 0;
    y = p / w;
    x = p % w;
    for (i = 0; i < kh; i++) begin
      for (j = 0; j < kw; j++) begin
        yy = y - kh / 2 + i;
        xx = x - kw / 2 + j;
        if (yy >= 0 && xx >= 0 && yy < h && xx < w) begin
          c = coef_rows[i][16*j +: 16];
          acc += longint'(c) * longint'(hist[(yy * w + xx) % HIST_DEPTH]);
        end
      end
    end
    if (acc <= 0) return 8'h00;
    t = acc >>> FRAC;
    if (t > 255) return 8'hFF;
    return t[7:0];
  endfunction

  task automatic take_word(logic act, logic [7:0] pix);
    int unsigned w, h, kw, kh, total, lag, n;
    logic all_in, emit;
    res_word_t r;
    w = clamp_dim(row_len, ROW_MAX);
    h = clamp_dim(frame_rows, ROWS_MAX);
    kw = clamp_dim(k_cols, KERNEL_MAX);
    kh = clamp_dim(k_rows, KERNEL_MAX);
    total = w * h;
    lag = (kh - 1 - kh / 2) * w + (kw - 1 - kw / 2);
    all_in = (row_pos >= h);
    emit = 1'b0;
    if (action_t'(act) == ACT_PIXEL && !all_in) begin
      n = row_pos * w + col_pos;
      hist[n % HIST_DEPTH] = pix;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
      emit = (n >= lag);
    end else if (all_in) begin
      emit = 1'b1;
    end
    if (emit) begin
      r.value = conv_at(out_pos, w, h, kw, kh);
      out_pos++;
      r.frame_last = (out_pos >= total);
      if (r.frame_last) begin
        col_pos = 0;
        row_pos = 0;
        out_pos = 0;
      end
      expected_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    res_word_t head;
    if (!rst_n) begin
      k_cols = 2'd3;
      k_rows = 2'd3;
      coef_rows[0] = 48'h0;
      coef_rows[1] = 48'h0000_0100_0000;
      coef_rows[2] = 48'h0;
      row_len = 12'd640;
      frame_rows = 12'd480;
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_KERNEL_WIDTH:  k_cols = cfg_data[1:0];
          REG_KERNEL_HEIGHT: k_rows = cfg_data[1:0];
          REG_KERNEL_TOP:    coef_rows[0] = cfg_data;
          REG_KERNEL_MID:    coef_rows[1] = cfg_data;
          REG_KERNEL_BOT:    coef_rows[2] = cfg_data;
          REG_ROW_BYTES:     row_len = cfg_data[11:0];
          REG_IMAGE_ROWS:    frame_rows = cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_word(in_action, in_pixel);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t unexpected result word: value %0d last %0b", $time,
                     out_value, out_frame_last);
        end else begin
          head = expected_q.pop_front();
          checked++;
          if (head.value !== out_value || head.frame_last !== out_frame_last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t result %0d: expected value %0d last %0b, got value %0d last %0b",
                       $time, checked, head.value, head.frame_last, out_value,
                       out_frame_last);
          end
        end
        if (mismatches == REPORT_MAX + 1)
          $display("%0t further mismatch reports suppressed", $time);
      end
    end
    pending = expected_q.size();
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

// Stimulus and verdict for the zero-padded 3x3 convolution. The checker beside
// the block does all prediction and comparison; this module only feeds words,
// writes registers between frames and throttles the result side.
module tb
  import zpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1700;  // useful words in the random part
  localparam int SETTLE       = 16;
  localparam int LONG_HOLD    = 300;   // long output stall, well past queue + pipe

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready, in_action;
  logic [7:0]  in_pixel;
  logic        out_valid, out_ready, out_frame_last;
  logic [7:0]  out_value;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  // acceptance seen at the last rising edge, read by the drivers at the falling edge
  logic        in_taken, cfg_taken;

  int mismatches, pending, checked;

  // shadow of the effective geometry, needed to size frames and their drain
  int unsigned cur_w, cur_h, cur_kw, cur_kh;

  int unsigned words_sent;
  int unsigned useful_words;   // words that are not ignored flushes
  int unsigned settings_used;
  int          burst_left;
  bit          steady;         // sender runs without gaps
  bit          hold_req;       // asks the receiver for one long stall
  int          holds_done;

  zero_padded_2d_convolution dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_frame_last(out_frame_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  conv_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_frame_last(out_frame_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .checked       (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always_ff @(posedge clk) begin
    in_taken  <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  // generous bound: far above the slowest legal run
  initial begin
    #(16_000_000);
    $display("tb: errors");
    $finish;
  end

  // Result side: random modes of random length; a long stall on request so the
  // block's queue fills and in_ready drops while the sender keeps offering.
  initial begin : receiver
    int mode, span, tick;
    out_ready = 1'b0;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 300);
        end
        span--;
        tick++;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= (tick % 5 != 0) && (tick % 5 != 3);
        endcase
      end
    end
  end

  function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;  // extremes
      2:       return 16'($urandom_range(0, 96));                   // blur-like
      3:       return 16'($urandom_range(0, 511) - 256);            // small signed
      4:       return 16'h0000;
      default: return 16'h0100;                                     // 1.0
    endcase
  endfunction

  function automatic logic [47:0] pick_coef_row();
    return {pick_coef(), pick_coef(), pick_coef()};
  endfunction

  function automatic logic [7:0] pick_byte(int fill);
    case (fill)
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2:       return 8'hFF;
      3:       return 8'($urandom_range(0, 15));
      default: return 8'($urandom);
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic put_word(logic act, logic [7:0] pix);
    in_valid  <= 1'b1;
    in_action <= act;
    in_pixel  <= pix;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    words_sent++;
  endtask

  // bursts of random length, random gaps between them unless steady
  task automatic offer(logic act, logic [7:0] pix);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 64);
      if (!steady && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    put_word(act, pix);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
  endtask

  task automatic set_config(logic [1:0] kw, logic [1:0] kh, logic [47:0] top,
                            logic [47:0] mid, logic [47:0] bot, logic [11:0] rb,
                            logic [11:0] ir);
    write_reg(REG_KERNEL_WIDTH, 48'(kw));
    write_reg(REG_KERNEL_HEIGHT, 48'(kh));
    write_reg(REG_KERNEL_TOP, top);
    write_reg(REG_KERNEL_MID, mid);
    write_reg(REG_KERNEL_BOT, bot);
    write_reg(REG_ROW_BYTES, 48'(rb));
    write_reg(REG_IMAGE_ROWS, 48'(ir));
    cfg_valid <= 1'b0;
    cur_w  = eff_dim(rb, 2048);
    cur_h  = eff_dim(ir, 4095);
    cur_kw = eff_dim(kw, KERNEL_MAX);
    cur_kh = eff_dim(kh, KERNEL_MAX);
    settings_used++;
  endtask

  // One frame of pixels, then the drain ticks for the outputs still in the
  // window lag. Noise adds ignored early flushes and pixels during the drain,
  // which the block treats as flushes.
  task automatic send_frame(logic [7:0] bytes [$], bit noisy);
    int unsigned lag;
    lag = (cur_kh - 1 - cur_kh / 2) * cur_w + (cur_kw - 1 - cur_kw / 2);
    foreach (bytes[k]) begin
      if (noisy && $urandom_range(0, 15) == 0) offer(ACT_FLUSH, 8'($urandom));
      offer(ACT_PIXEL, bytes[k]);
    end
    repeat (lag) begin
      if (noisy && $urandom_range(0, 3) == 0) offer(ACT_PIXEL, 8'($urandom));
      else offer(ACT_FLUSH, 8'($urandom));
    end
    useful_words += bytes.size() + lag;
  endtask

  task automatic random_frame(int fill, bit noisy);
    logic [7:0] bytes [$];
    repeat (cur_w * cur_h) bytes.push_back(pick_byte(fill));
    send_frame(bytes, noisy);
  endtask

  // idle point: every prediction met, then a settling wait for words with no result
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [7:0]  bytes [$];
    logic [1:0]  kw, kh;
    logic [11:0] rb, ir;
    int unsigned start;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_action  = ACT_PIXEL;
    in_pixel   = 8'h00;
    cfg_valid  = 1'b0;
    cfg_index  = REG_KERNEL_WIDTH;
    cfg_data   = 48'h0;
    hold_req   = 1'b0;
    steady     = 1'b0;
    burst_left = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // --- directed ---
    // Reset kernel is the 3x3 identity: shrink only the raster and expect the
    // input back, including the pixel extremes.
    write_reg(REG_ROW_BYTES, 48'd4);
    write_reg(REG_IMAGE_ROWS, 48'd3);
    cfg_valid <= 1'b0;
    cur_w  = 4;
    cur_h  = 3;
    cur_kw = 3;
    cur_kh = 3;
    offer(ACT_FLUSH, 8'hFF);  // flush before any pixel: ignored
    bytes = {8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h01, 8'h80,
             8'hFE, 8'h7F, 8'h33, 8'hCC};
    send_frame(bytes, 1'b0);
    settle();

    // zero kernel size and zero raster size act as 1: single-byte frames,
    // largest positive coefficient, saturation at the top
    set_config(2'd0, 2'd0, 48'h7FFF, 48'h0, 48'h0, 12'd0, 12'd0);
    bytes = {8'h01};
    send_frame(bytes, 1'b0);
    bytes = {8'hFF};
    send_frame(bytes, 1'b0);
    bytes = {8'h00};
    send_frame(bytes, 1'b0);
    settle();

    // mixed extreme coefficients on a 2x2 raster
    set_config(2'd3, 2'd3, {16'h7FFF, 16'h8000, 16'h7FFF},
               {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h7FFF, 16'h7FFF},
               12'd2, 12'd2);
    bytes = {8'hFF, 8'h00, 8'hFF, 8'hFF};
    send_frame(bytes, 1'b0);
    settle();

    // --- tall frame ---
    // one byte per row, with a long output stall as the frame starts
    set_config(2'd3, 2'd3, pick_coef_row(), pick_coef_row(), pick_coef_row(),
               12'd0, 12'd96);
    hold_req = 1'b1;
    random_frame(0, 1'b1);
    settle();

    // --- random ---
    start = useful_words;
    hold_req = 1'b1;
    while (useful_words - start < RANDOM_WORDS) begin
      steady = ($urandom_range(0, 4) == 0);
      kw = 2'($urandom_range(0, 3));
      kh = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0:       rb = 12'($urandom_range(0, 2));
        6:       rb = 12'($urandom_range(17, 48));
        7:       rb = 12'($urandom_range(49, 100));
        default: rb = 12'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 5))
        0:       ir = 12'($urandom_range(0, 1));
        5:       ir = 12'($urandom_range(7, 12));
        default: ir = 12'($urandom_range(2, 6));
      endcase
      set_config(kw, kh, pick_coef_row(), pick_coef_row(), pick_coef_row(), rb, ir);
      repeat ($urandom_range(1, 3)) begin
        if (useful_words - start < RANDOM_WORDS)
          random_frame($urandom_range(0, 4), $urandom_range(0, 7) != 0);
      end
      settle();
    end

    $display("tb: %0d input words accepted (%0d not ignored) across %0d register settings",
             words_sent, useful_words, settings_used);
    $display("tb: %0d result words compared, %0d long output stalls", checked, holds_done);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
